// ----- src/bba_pkg.sv -----
// Package for the buddy block allocator: field widths, codes, defaults and
// sequencer states. No dependencies.
package bba_pkg;

  // Parameter defaults
  localparam int MAX_ORDER_DEF = 6;
  localparam int ID_BITS_DEF   = 16;

  // Fixed field widths
  localparam int KIND_W  = 1;
  localparam int OWNER_W = 16;
  localparam int SIZE_W  = 7;
  localparam int COUNT_W = 7;
  localparam int ORD_W   = 3;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-3:0] REG_TOTAL_ORDER = 1'b0;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
  localparam logic [KIND_W-1:0] KIND_QUERY = 1'b1;

  // Result status
  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_OOM = 1'b1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_PLAN,
    ST_SHIFT,
    ST_FILL,
    ST_DONE,
    ST_QRD,
    ST_QOUT
  } bba_state_t;

endpackage

// ----- src/bba_if.sv -----
// Valid/ready channel interfaces for the allocator's request and result beats.
// Depends on bba_pkg.
interface bba_in_if import bba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [OWNER_W-1:0] owner_id;
  logic [SIZE_W-1:0]  request_size;

  modport source (output valid, kind, owner_id, request_size, input ready);
  modport sink   (input valid, kind, owner_id, request_size, output ready);
endinterface

interface bba_out_if import bba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] block_count;
  logic [OWNER_W-1:0] block_owner;
  logic               is_last;
  logic               status;

  modport source (output valid, block_count, block_owner, is_last, status, input ready);
  modport sink   (input valid, block_count, block_owner, is_last, status, output ready);
endinterface

// ----- src/buddy_block_allocator.sv -----
// Buddy block allocator top level: table memory, sequencer and APB register.
// Depends on bba_pkg and the channel interfaces in bba_if.sv.

// The block keeps an address-ordered table of power-of-two blocks in a
// single-port-read, single-port-write memory of 2^MAX_ORDER entries; after
// reset or any write of total_order it holds one free block of that order
// (entry 0 is written first, input not ready meanwhile). One item is
// worked at a time; in_if.ready is high only while the sequencer is idle.
// After its accept, an allocate beat scans the N blocks in the table, one
// read per block (the scan ends on an exact fit), plans the split when no
// exact fit exists, shifts any entries above the split block up by d,
// writes d + 1 fill entries (d = order difference, 0 on an exact fit, no
// fill on out of memory) and loads the result: all of it paced by the one
// memory read port and the one order compare. It answers with one beat.
// A query beat answers with N beats, one memory read per block. Sizes above
// the pool, no free block large enough, or a split that would overflow the
// table give status out of memory with the table unchanged.
// Blocks are never freed.
// A result register parts the output; back-pressure only stalls the sequencer.
module buddy_block_allocator import bba_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF,
  parameter int ID_BITS   = ID_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  bba_in_if.sink            in_if,
  bba_out_if.source         out_if,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int DEPTH = 1 << MAX_ORDER;
  localparam int AW    = MAX_ORDER;
  localparam int CNT_W = MAX_ORDER + 1;
  localparam int OWN_W = (ID_BITS < OWNER_W) ? ID_BITS : OWNER_W;
  localparam int MW    = ORD_W + OWN_W;

  // size rounded up to an order: count of powers 2^i below size, i = 0..6
  function automatic logic [ORD_W-1:0] size_to_order(input logic [SIZE_W-1:0] size);
    logic [ORD_W-1:0] k;
    k = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if ((SIZE_W+1)'(1 << i) < (SIZE_W+1)'(size)) begin
        k = k + ORD_W'(1);
      end
    end
    return k;
  endfunction

  // table memory: {order, owner} per entry
  logic [MW-1:0] mem [DEPTH];
  logic [MW-1:0] rdata_r;
  logic          re, we;
  logic [AW-1:0] ra, wa;
  logic [MW-1:0] wd;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_r <= mem[ra];
    end
  end

  logic [ORD_W-1:0] rd_ord;
  logic [OWN_W-1:0] rd_own;
  logic             rd_free;
  assign rd_ord  = rdata_r[MW-1 -: ORD_W];
  assign rd_own  = rdata_r[OWN_W-1:0];
  assign rd_free = (rd_own == '0);

  // sequencer registers
  bba_state_t       state_r, state_nxt;
  logic [ORD_W-1:0] tord_r, tord_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [OWN_W-1:0] owner_r, owner_nxt;
  logic [ORD_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;        // scan issue index
  logic [AW-1:0]    ev_idx_r, ev_idx_nxt;  // index of data in rdata_r
  logic             pend_r, pend_nxt;
  logic             big_v_r, big_v_nxt;
  logic [AW-1:0]    big_idx_r, big_idx_nxt;
  logic [ORD_W-1:0] big_ord_r, big_ord_nxt;
  logic [AW-1:0]    base_r, base_nxt;
  logic [ORD_W-1:0] d_r, d_nxt;
  logic [AW-1:0]    sj_r, sj_nxt;          // shift read index
  logic [AW-1:0]    swj_r, swj_nxt;        // index whose data is in flight
  logic             spend_r, spend_nxt;
  logic             sdone_r, sdone_nxt;
  logic [ORD_W-1:0] m_r, m_nxt;
  logic             status_r, status_nxt;
  logic [AW-1:0]    qi_r, qi_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic [OWNER_W-1:0] out_owner_r, out_owner_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_status_r, out_status_nxt;

  logic slot_free;
  logic cfg_wr;
  logic cfg_hit;
  logic q_last;

  assign slot_free = !out_valid_r || out_if.ready;
  assign cfg_hit   = (cfg_paddr[CFG_AW-1:2] == REG_TOTAL_ORDER);
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;
  assign q_last    = ((CNT_W'(qi_r) + CNT_W'(1)) == cnt_r);

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_hit ? CFG_DW'(tord_r) : '0;

  assign in_if.ready        = (state_r == ST_IDLE);
  assign out_if.valid       = out_valid_r;
  assign out_if.block_count = out_count_r;
  assign out_if.block_owner = out_owner_r;
  assign out_if.is_last     = out_last_r;
  assign out_if.status      = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      tord_r      <= ORD_W'(MAX_ORDER);
      cnt_r       <= CNT_W'(1);
      pend_r      <= 1'b0;
      big_v_r     <= 1'b0;
      spend_r     <= 1'b0;
      sdone_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tord_r      <= tord_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      big_v_r     <= big_v_nxt;
      spend_r     <= spend_nxt;
      sdone_r     <= sdone_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    owner_r      <= owner_nxt;
    k_r          <= k_nxt;
    idx_r        <= idx_nxt;
    ev_idx_r     <= ev_idx_nxt;
    big_idx_r    <= big_idx_nxt;
    big_ord_r    <= big_ord_nxt;
    base_r       <= base_nxt;
    d_r          <= d_nxt;
    sj_r         <= sj_nxt;
    swj_r        <= swj_nxt;
    m_r          <= m_nxt;
    status_r     <= status_nxt;
    qi_r         <= qi_nxt;
    out_count_r  <= out_count_nxt;
    out_owner_r  <= out_owner_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    tord_nxt       = tord_r;
    cnt_nxt        = cnt_r;
    owner_nxt      = owner_r;
    k_nxt          = k_r;
    idx_nxt        = idx_r;
    ev_idx_nxt     = ev_idx_r;
    pend_nxt       = pend_r;
    big_v_nxt      = big_v_r;
    big_idx_nxt    = big_idx_r;
    big_ord_nxt    = big_ord_r;
    base_nxt       = base_r;
    d_nxt          = d_r;
    sj_nxt         = sj_r;
    swj_nxt        = swj_r;
    spend_nxt      = spend_r;
    sdone_nxt      = sdone_r;
    m_nxt          = m_r;
    status_nxt     = status_r;
    qi_nxt         = qi_r;
    out_count_nxt  = out_count_r;
    out_owner_nxt  = out_owner_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    re = 1'b0;
    ra = '0;
    we = 1'b0;
    wa = '0;
    wd = '0;

    case (state_r)
      ST_INIT: begin
        // table restarts as one free block of total order
        we        = 1'b1;
        wa        = '0;
        wd        = {tord_r, OWN_W'(0)};
        cnt_nxt   = CNT_W'(1);
        state_nxt = ST_IDLE;
      end

      ST_IDLE: begin
        if (in_if.valid) begin
          owner_nxt = in_if.owner_id[OWN_W-1:0];
          k_nxt     = size_to_order(in_if.request_size);
          if (in_if.kind == KIND_QUERY) begin
            qi_nxt    = '0;
            state_nxt = ST_QRD;
          end else begin
            idx_nxt   = '0;
            pend_nxt  = 1'b0;
            big_v_nxt = 1'b0;
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // one read issued and one entry checked per cycle
        if (pend_r && rd_free && (rd_ord == k_r)) begin
          base_nxt   = ev_idx_r;
          d_nxt      = '0;
          m_nxt      = '0;
          pend_nxt   = 1'b0;
          status_nxt = STAT_OK;
          state_nxt  = ST_FILL;
        end else begin
          if (pend_r && rd_free && (rd_ord > k_r) && !big_v_r) begin
            big_v_nxt   = 1'b1;
            big_idx_nxt = ev_idx_r;
            big_ord_nxt = rd_ord;
          end
          if (idx_r < cnt_r) begin
            re         = 1'b1;
            ra         = idx_r[AW-1:0];
            ev_idx_nxt = idx_r[AW-1:0];
            pend_nxt   = 1'b1;
            idx_nxt    = idx_r + CNT_W'(1);
          end else begin
            pend_nxt = 1'b0;
            if (!pend_r) begin
              state_nxt = ST_PLAN;
            end
          end
        end
      end

      ST_PLAN: begin
        // split the first larger free block down to the needed order at once, or give out of memory
        if (!big_v_r) begin
          status_nxt = STAT_OOM;
          state_nxt  = ST_DONE;
        end else if ((CNT_W+1)'(cnt_r) + (CNT_W+1)'(big_ord_r - k_r)
                     > (CNT_W+1)'(DEPTH)) begin
          status_nxt = STAT_OOM;
          state_nxt  = ST_DONE;
        end else begin
          status_nxt = STAT_OK;
          d_nxt      = big_ord_r - k_r;
          base_nxt   = big_idx_r;
          m_nxt      = '0;
          if ((CNT_W'(big_idx_r) + CNT_W'(1)) < cnt_r) begin
            sj_nxt    = AW'(cnt_r - CNT_W'(1));
            spend_nxt = 1'b0;
            sdone_nxt = 1'b0;
            state_nxt = ST_SHIFT;
          end else begin
            state_nxt = ST_FILL;
          end
        end
      end

      ST_SHIFT: begin
        // move entries above the split block up by d, top entry first
        if (spend_r) begin
          we = 1'b1;
          wa = AW'(CNT_W'(swj_r) + CNT_W'(d_r));
          wd = rdata_r;
        end
        if (!sdone_r) begin
          re        = 1'b1;
          ra        = sj_r;
          swj_nxt   = sj_r;
          spend_nxt = 1'b1;
          if (sj_r == base_r + AW'(1)) begin
            sdone_nxt = 1'b1;
          end else begin
            sj_nxt = sj_r - AW'(1);
          end
        end else begin
          spend_nxt = 1'b0;
          if (!spend_r) begin
            state_nxt = ST_FILL;
          end
        end
      end

      ST_FILL: begin
        // owned block at base, then free buddies of orders k, k+1, ...
        we = 1'b1;
        wa = base_r + AW'(m_r);
        if (m_r == '0) begin
          wd = {k_r, owner_r};
        end else begin
          wd = {k_r + m_r - ORD_W'(1), OWN_W'(0)};
        end
        if (m_r == d_r) begin
          cnt_nxt   = cnt_r + CNT_W'(d_r);
          state_nxt = ST_DONE;
        end else begin
          m_nxt = m_r + ORD_W'(1);
        end
      end

      ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_count_nxt  = COUNT_W'(cnt_r);
          out_owner_nxt  = OWNER_W'(owner_r);
          out_last_nxt   = 1'b1;
          out_status_nxt = status_r;
          state_nxt      = ST_IDLE;
        end
      end

      ST_QRD: begin
        re        = 1'b1;
        ra        = qi_r;
        state_nxt = ST_QOUT;
      end

      ST_QOUT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_count_nxt  = COUNT_W'(cnt_r);
          out_owner_nxt  = OWNER_W'(rd_own);
          out_last_nxt   = q_last;
          out_status_nxt = STAT_OK;
          if (q_last) begin
            state_nxt = ST_IDLE;
          end else begin
            qi_nxt    = qi_r + AW'(1);
            state_nxt = ST_QRD;
          end
        end
      end

      default: begin
        state_nxt = ST_INIT;
      end
    endcase

    // register write restarts the table; the user must write it only while idle, the block does not enforce it
    if (cfg_wr) begin
      if (cfg_pwdata[ORD_W-1:0] > ORD_W'(MAX_ORDER)) begin
        tord_nxt = ORD_W'(MAX_ORDER);
      end else begin
        tord_nxt = cfg_pwdata[ORD_W-1:0];
      end
      state_nxt = ST_INIT;
    end
  end

endmodule

// ----- verif/bba_checker.sv -----
// Scoreboard for the buddy block allocator: mirrors the block table, predicts
// every result beat and compares it with the result channel.
// Depends on bba_pkg and the channel interfaces in bba_if.sv.
module bba_checker import bba_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  bba_in_if                 in_ch,
  bba_out_if                out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic              cfg_pready,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output int                fail_count,
  output int                beats_owed
);

  localparam int TABLE_DEPTH = 1 << MAX_ORDER_DEF;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [OWNER_W-1:0] owner;
    logic               last;
    logic               status;
  } answer_t;

  answer_t            owed_answers[$];
  logic [ORD_W-1:0]   pool_order;
  logic [ORD_W-1:0]   blk_order[TABLE_DEPTH];
  logic [OWNER_W-1:0] blk_owner[TABLE_DEPTH];
  int                 blk_count;

  function automatic void restart_pool();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      blk_order[i] = '0;
      blk_owner[i] = '0;
    end
    blk_order[0] = pool_order;
    blk_count    = 1;
  endfunction

  function automatic int order_for_size(input logic [SIZE_W-1:0] size);
    int k;
    k = 0;
    while (k < 8 && (1 << k) < int'(size))
      k++;
    return k;
  endfunction

  // first free block of order k (exact) or above k; -1 when there is none
  function automatic int first_free(input int k, input bit exact);
    for (int i = 0; i < blk_count; i++) begin
      if (blk_owner[i] != '0)
        continue;
      if (exact ? (int'(blk_order[i]) == k) : (int'(blk_order[i]) > k))
        return i;
    end
    return -1;
  endfunction

  function automatic void allocate_block(input logic [OWNER_W-1:0] owner,
                                         input logic [SIZE_W-1:0] size);
    int      need;
    int      hit;
    int      big;
    answer_t ans;
    need       = order_for_size(size);
    hit        = first_free(need, 1'b1);
    ans.status = STAT_OK;
    while (hit < 0) begin
      big = first_free(need, 1'b0);
      if (big < 0 || blk_count >= TABLE_DEPTH) begin
        ans.status = STAT_OOM;
        break;
      end
      // halve the block, its buddy goes right behind it
      blk_order[big] = blk_order[big] - 1'b1;
      for (int j = blk_count; j > big + 1; j--) begin
        blk_order[j] = blk_order[j-1];
        blk_owner[j] = blk_owner[j-1];
      end
      blk_order[big+1] = blk_order[big];
      blk_owner[big+1] = '0;
      blk_count++;
      hit = first_free(need, 1'b1);
    end
    if (hit >= 0)
      blk_owner[hit] = owner;
    ans.count = COUNT_W'(blk_count);
    ans.owner = owner;
    ans.last  = 1'b1;
    owed_answers.push_back(ans);
  endfunction

  function automatic void list_blocks();
    answer_t ans;
    for (int i = 0; i < blk_count; i++) begin
      ans.count  = COUNT_W'(blk_count);
      ans.owner  = blk_owner[i];
      ans.last   = (i == blk_count - 1);
      ans.status = STAT_OK;
      owed_answers.push_back(ans);
    end
  endfunction

  function automatic void check_beat();
    answer_t want;
    if (owed_answers.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("[%0t] unexpected result beat: count=%0d owner=%h last=%b status=%b",
                 $realtime, out_ch.block_count, out_ch.block_owner, out_ch.is_last,
                 out_ch.status);
      return;
    end
    want = owed_answers.pop_front();
    if (out_ch.block_count !== want.count || out_ch.block_owner !== want.owner ||
        out_ch.is_last !== want.last || out_ch.status !== want.status) begin
      fail_count++;
      if (fail_count <= 10)
        $display("[%0t] result mismatch: exp count=%0d owner=%h last=%b status=%b,",
                 $realtime, want.count, want.owner, want.last, want.status,
                 " got count=%0d owner=%h last=%b status=%b",
                 out_ch.block_count, out_ch.block_owner, out_ch.is_last, out_ch.status);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pool_order = ORD_W'(MAX_ORDER_DEF);
      restart_pool();
      owed_answers.delete();
      fail_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        check_beat();
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.kind == KIND_QUERY)
          list_blocks();
        else
          allocate_block(in_ch.owner_id, in_ch.request_size);
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[CFG_AW-1:2] == REG_TOTAL_ORDER) begin
        pool_order = (int'(cfg_pwdata[ORD_W-1:0]) > MAX_ORDER_DEF) ?
                     ORD_W'(MAX_ORDER_DEF) : cfg_pwdata[ORD_W-1:0];
        restart_pool();
      end
    end
    beats_owed = owed_answers.size();
  end

endmodule

// ----- verif/buddy_block_allocator_tb.sv -----
// Top of the buddy block allocator testbench: clock, reset, request stimulus,
// result back-pressure, register writes and the verdict.
// Depends on bba_pkg, bba_if.sv, the allocator RTL and bba_checker.
module buddy_block_allocator_tb;
  import bba_pkg::*;

  localparam int ITEMS_TARGET = 480;
  localparam int CALM_ITEMS   = 60;        // last stretch runs without idling
  localparam int LONG_HOLD    = 600;       // receiver hold-off, in cycles
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int SETTLE       = 40;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  bba_in_if  in_ch();
  bba_out_if out_ch();

  int fail_count;
  int beats_owed;
  int sent;            // request beats accepted so far
  int pool_now;        // effective pool order after the last write
  int hold_requests;   // bumped by the stimulus, served by the result sink
  bit calm;            // no idling on either side once set

  buddy_block_allocator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  bba_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .fail_count  (fail_count),
    .beats_owed  (beats_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: sized for every item at 64 beats, each beat under the longest stall burst.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // Result sink: random stall bursts, plus one long hold-off on request so the
  // result register fills and the block stops taking requests.
  initial begin : result_sink
    int stall_left;
    int hold_left;
    int holds_served;
    stall_left   = 0;
    hold_left    = 0;
    holds_served = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // All tasks below are entered and left right after a falling edge.

  // One request beat, optionally after an idle burst. valid is left high on
  // accept so back-to-back beats need only one assignment per edge.
  task automatic offer_item(input logic [KIND_W-1:0]  kind,
                            input logic [OWNER_W-1:0] owner,
                            input logic [SIZE_W-1:0]  size);
    int gap;
    calm = (sent >= ITEMS_TARGET - CALM_ITEMS);
    gap  = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 9) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.owner_id     <= owner;
    in_ch.request_size <= size;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    sent++;
  endtask

  // Stop sending and wait out every owed beat; the block has no silent items,
  // so a short settle covers the result register and the sequencer.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (beats_owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_pool_order(input logic [ORD_W-1:0] ord);
    drain();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_TOTAL_ORDER, 2'b00};
    cfg_pwdata  <= CFG_DW'(ord);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    pool_now = (int'(ord) > MAX_ORDER_DEF) ? MAX_ORDER_DEF : int'(ord);
  endtask

  task automatic query_blocks();
    offer_item(KIND_QUERY, OWNER_W'($urandom), SIZE_W'($urandom));
  endtask

  // Mostly sizes that fit the pool, spread over the orders; style 0 asks for
  // unit blocks so the table splits all the way down to full.
  task automatic random_alloc(input int style);
    logic [OWNER_W-1:0] owner;
    logic [SIZE_W-1:0]  size;
    int                 k;
    owner = ($urandom_range(0, 15) == 0) ? '0 : OWNER_W'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      size = SIZE_W'($urandom_range(0, 127));
    end else if (style == 0) begin
      size = SIZE_W'($urandom_range(0, 1));
    end else begin
      k    = $urandom_range(0, pool_now);
      size = (k == 0) ? SIZE_W'(1) : SIZE_W'($urandom_range((1 << (k - 1)) + 1, 1 << k));
    end
    offer_item(KIND_ALLOC, owner, size);
  endtask

  initial begin : stimulus
    int  style;
    int  phase_len;
    int  ord;
    bit  hold_done;
    rst_n         = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = KIND_ALLOC;
    in_ch.owner_id     = '0;
    in_ch.request_size = '0;
    sent          = 0;
    pool_now      = MAX_ORDER_DEF;
    hold_requests = 0;
    calm          = 1'b0;
    hold_done     = 1'b0;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset table, size zero, zero owner, every order, sizes past
    // the pool and past the widest order.
    query_blocks();
    offer_item(KIND_ALLOC, 16'hFFFF, 7'd0);
    offer_item(KIND_ALLOC, 16'h0000, 7'd1);
    offer_item(KIND_ALLOC, 16'h0001, 7'd1);
    offer_item(KIND_ALLOC, 16'h8000, 7'd2);
    offer_item(KIND_ALLOC, 16'hAAAA, 7'd3);
    offer_item(KIND_ALLOC, 16'h5555, 7'd4);
    offer_item(KIND_ALLOC, 16'h1234, 7'd5);
    offer_item(KIND_ALLOC, 16'h0F0F, 7'd16);
    offer_item(KIND_ALLOC, 16'h00FF, 7'd17);
    offer_item(KIND_ALLOC, 16'h7FFE, 7'd64);
    offer_item(KIND_ALLOC, 16'hC3C3, 7'd127);
    offer_item(KIND_ALLOC, 16'h3C3C, 7'd65);
    query_blocks();

    // smallest pool: one unit, then out of memory
    set_pool_order(3'd0);
    offer_item(KIND_ALLOC, 16'h0042, 7'd1);
    offer_item(KIND_ALLOC, 16'h0043, 7'd1);
    offer_item(KIND_ALLOC, 16'h0044, 7'd2);
    query_blocks();

    // order 7 saturates to the widest pool; whole-pool grab
    set_pool_order(3'd7);
    query_blocks();
    offer_item(KIND_ALLOC, 16'h7777, 7'd64);
    query_blocks();

    // Random phases, each from a fresh table and a drained pipe.
    while (sent < ITEMS_TARGET) begin
      style = $urandom_range(0, 2);
      ord   = (style == 0) ? $urandom_range(6, 7) : $urandom_range(0, 7);
      set_pool_order(ORD_W'(ord));
      phase_len = (style == 0) ? $urandom_range(40, 70) : $urandom_range(12, 35);
      for (int n = 0; n < phase_len && sent < ITEMS_TARGET; n++) begin
        // one long receiver hold-off while requests keep coming
        if (!hold_done && sent >= 200) begin
          hold_requests++;
          hold_done = 1'b1;
        end
        if ($urandom_range(0, 6) == 0)
          query_blocks();
        else
          random_alloc(style);
      end
      query_blocks();
    end

    in_ch.valid <= 1'b0;
    while (beats_owed != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
